// File: hw/rtl/rmf_pkg.sv
// Shared types for the running median filter core.
// Holds the window entry and neighbor link records used by the sorted cell chain.
// No dependencies.
package rmf_pkg;

	localparam int SAMPLE_W = 16;
	// Ages reach at most WINDOW-1, and WINDOW is at most 16.
	localparam int AGE_W = 4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t          value;
		logic             pad;
		logic [AGE_W-1:0] age;
	} rmf_entry_t;

	typedef struct packed {
		rmf_entry_t entry;
		logic       less;
	} rmf_link_t;

endpackage

// File: hw/rtl/rmf_cell.sv
// One cell of the sorted window chain of the running median filter.
// Holds one window entry and swaps it with its neighbors when a word is taken.
// Depends on rmf_pkg.
module rmf_cell #(
	parameter int WINDOW = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift_en,
	input  rmf_pkg::sample_t   sample,
	input  rmf_pkg::rmf_link_t left_link,
	input  rmf_pkg::rmf_link_t right_link,
	input  logic               cand_before,
	output logic               cand_thru,
	output rmf_pkg::rmf_link_t own_link
);
	import rmf_pkg::*;

	rmf_entry_t entry_q;
	rmf_entry_t src;
	rmf_entry_t entry_next;
	logic       cand;
	logic       less;
	logic       take_left;
	logic       take_right;
	logic       keep;

	// A cell is a removal candidate if it is padding or holds the oldest sample.
	// The lowest candidate in the chain is the one that leaves.
	assign cand      = entry_q.pad || (entry_q.age == AGE_W'(WINDOW - 1));
	assign cand_thru = cand_before | cand;
	assign less      = entry_q.value <= sample;
	assign own_link  = '{entry: entry_q, less: less};

	assign take_right = right_link.less && cand_thru;
	assign take_left  = !left_link.less && !cand_before;
	assign keep       = !(cand && !cand_before) &&
		((less && !cand_thru) || (!less && cand_before));

	always_comb begin
		if (keep) begin
			src = entry_q;
		end else if (take_right) begin
			src = right_link.entry;
		end else if (take_left) begin
			src = left_link.entry;
		end else begin
			src = '{value: sample, pad: 1'b0, age: '0};
		end
		entry_next = src;
		if (!src.pad && (keep || take_right || take_left)) begin
			entry_next.age = src.age + AGE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '{value: '0, pad: 1'b1, age: '0};
		end else if (shift_en) begin
			entry_q <= entry_next;
		end
	end

endmodule

// File: hw/rtl/running_median_filter_core.sv
// Running median filter core: a sorted chain of WINDOW cells, zero padded.
// The result word for a sample is offered in the cycle after the sample is taken.
// Throughput: one sample per cycle while no result is pending or m_tready is high; each
// cell compares against the new sample and shifts by at most one place.
// Reset: every cell holds a padding zero, the fill count is zero, no result is pending.
module running_median_filter_core #(
	parameter int WINDOW = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [rmf_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [rmf_pkg::SAMPLE_W-1:0] m_tdata    // [15:0] median_value
);
	import rmf_pkg::*;

	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int IDX_W  = $clog2(WINDOW);

	logic              accept;
	logic              out_valid_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] rank;
	sample_t           sample;
	rmf_link_t         links [WINDOW];
	logic              cand  [WINDOW+1];
	rmf_link_t         left_edge;
	rmf_link_t         right_edge;

	assign sample   = s_tdata;
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Edge links never supply data: the left edge reads as smaller, the right as larger.
	assign left_edge  = '{entry: '{value: '0, pad: 1'b1, age: '0}, less: 1'b1};
	assign right_edge = '{entry: '{value: '0, pad: 1'b1, age: '0}, less: 1'b0};
	assign cand[0]    = 1'b0;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		rmf_cell #(
			.WINDOW(WINDOW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (accept),
			.sample     (sample),
			.left_link  ((i == 0) ? left_edge : links[(i == 0) ? 0 : i - 1]),
			.right_link ((i == WINDOW - 1) ? right_edge
				: links[(i == WINDOW - 1) ? WINDOW - 1 : i + 1]),
			.cand_before(cand[i]),
			.cand_thru  (cand[i+1]),
			.own_link   (links[i])
		);
	end

	// The result sits at rank WINDOW-1-count/2 of the sorted, zero-padded window.
	assign rank     = FILL_W'(WINDOW - 1) - (fill_q >> 1);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = links[rank[IDX_W-1:0]].entry.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			fill_q      <= '0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				if (fill_q < FILL_W'(WINDOW)) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: tb/tb_running_median_filter_core.sv
// Self-checking testbench for running_median_filter_core: drives sample words with random
// idling and back-pressure, and checks every median word against an in-bench predictor.
// Depends on rmf_pkg and running_median_filter_core only.
`timescale 1ns / 100ps

module tb_running_median_filter_core;

	import rmf_pkg::*;

	localparam int WINDOW = 7;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_tdata;

	// Predictor state: window contents, next slot and fill level.
	sample_t     window_mem [WINDOW];
	int unsigned wr_slot  = 0;
	int unsigned fill_cnt = 0;

	sample_t median_q [$];
	int      n_sent    = 0;
	int      n_checked = 0;
	int      n_errors  = 0;

	bit      tx_idle_on = 1'b1;
	bit      rx_idle_on = 1'b1;
	int      hold_req   = 0;
	int      hold_left  = 0;
	sample_t last_smp   = '0;

	running_median_filter_core #(
		.WINDOW(WINDOW)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("Timeout at %0t with %0d medians outstanding", $time, median_q.size());
		$display("Some tests failed");
		$finish;
	end

	// Writes the sample into the window, then picks the rank from the zero-padded sorted set.
	function automatic sample_t predict_median(input sample_t smp);
		sample_t sorted [WINDOW];
		sample_t key;
		int      j;
		window_mem[wr_slot] = smp;
		wr_slot = (wr_slot == WINDOW - 1) ? 0 : wr_slot + 1;
		if (fill_cnt < WINDOW)
			fill_cnt++;
		for (int i = 0; i < WINDOW; i++)
			sorted[i] = (i < fill_cnt) ? window_mem[i] : sample_t'(0);
		for (int i = 1; i < WINDOW; i++) begin
			key = sorted[i];
			j = i;
			while (j > 0 && sorted[j-1] > key) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = key;
		end
		return sorted[WINDOW - 1 - fill_cnt / 2];
	endfunction

	function automatic sample_t random_sample();
		int      pick;
		sample_t v;
		pick = $urandom_range(9);
		case (pick)
			0, 1, 2, 3: v = sample_t'($urandom);
			4, 5: v = sample_t'(int'($urandom_range(16)) - 8);
			6: begin
				case ($urandom_range(4))
					0: v = 16'sh7FFF;
					1: v = 16'sh8000;
					2: v = 16'sh0000;
					3: v = 16'shFFFF;
					default: v = 16'sh0001;
				endcase
			end
			// Repeats make ties in the sorted set.
			7: v = last_smp;
			default: v = sample_t'($urandom_range(32767));
		endcase
		last_smp = v;
		return v;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_sample(input sample_t smp);
		while (tx_idle_on && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Input acceptance feeds the predictor; output acceptance is checked against it.
	always @(posedge clk) begin
		sample_t want;
		if (arst_n && s_tvalid && s_tready) begin
			median_q.push_back(predict_median(sample_t'(s_tdata)));
			n_sent++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (median_q.size() == 0) begin
				$display("%0t: unexpected median word 0x%04h", $time, m_tdata);
				n_errors++;
			end else begin
				want = median_q.pop_front();
				if (m_tdata !== want) begin
					$display("%0t: median_value expected %0d (0x%04h), actual %0d (0x%04h)",
						$time, want, want, $signed(m_tdata), m_tdata);
					n_errors++;
				end
			end
			n_checked++;
		end
	end

	// Output side: random stalls, plus a long hold-off when a test asks for one.
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (!rx_idle_on) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 20);
		end
	end

	// Fill-up with mixed signs, where a padding zero can win, then full windows at the extremes.
	task automatic test_directed_fill();
		int dir_vals [] = '{-5, 100, -32768, 32767, -1, 0, 12,
			32767, 32767, 32767, 32767,
			-32768, -32768, -32768, -32768, -32768, -32768, -32768,
			1, 21845, -21846, 0, -1, 32767};
		foreach (dir_vals[i])
			send_sample(sample_t'(dir_vals[i]));
	endtask

	task automatic test_random_stream(input int count);
		repeat (count)
			send_sample(random_sample());
	endtask

	// The output holds off long enough for the block to fill and stall its input.
	task automatic test_output_stall();
		tx_idle_on = 1'b0;
		hold_req   = 80;
		repeat (40)
			send_sample(random_sample());
		tx_idle_on = 1'b1;
	endtask

	// The sender waits until every expected median has come before going on.
	task automatic test_drain_pause();
		repeat (50)
			send_sample(random_sample());
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (median_q.size() != 0)
			@(negedge clk);
		repeat (50)
			send_sample(random_sample());
	endtask

	task automatic test_full_rate();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (200)
			send_sample(random_sample());
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		int guard;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_fill();
		test_random_stream(600);
		test_output_stall();
		test_drain_pause();
		test_full_rate();
		test_random_stream(540);

		s_tvalid <= 1'b0;
		guard = 0;
		while (median_q.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (5) @(posedge clk);
		if (median_q.size() != 0) begin
			$display("%0t: %0d expected medians never arrived", $time, median_q.size());
			n_errors++;
		end

		$display("Sent %0d samples and checked %0d median words: fill-up, window wrap,",
			n_sent, n_checked);
		$display("extremes and ties, a long output stall, a drain pause and full-rate flow.");
		if (n_errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
